/* rtl/hsc_pkg.sv */
// ----------------------------------------------------------------------------
// hsc_pkg
// Sizes, codes and bit-placement helpers of the row Hamming SEC codec.
// ----------------------------------------------------------------------------
package hsc_pkg;

    localparam int DATA_BYTES = 4;
    localparam int BYTE_W     = 8;
    localparam int M          = DATA_BYTES * BYTE_W;

    function automatic int calc_r(input int m);
        int r;
        r = 0;
        while ((m + r + 1) > (1 << r)) begin
            r = r + 1;
        end
        return r;
    endfunction

    localparam int R = calc_r(M);
    localparam int N = M + R;

    // fixed field widths on the ports
    localparam int DATA_W = 32;
    localparam int CODE_W = 38;
    localparam int SYN_W  = 6;
    localparam int STAT_W = 2;
    localparam int S_TDATA_W = ((DATA_W + CODE_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = CODE_W + DATA_W + SYN_W + STAT_W;
    localparam int M_TDATA_W = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic {
        KIND_ENC = 1'b0,
        KIND_DEC = 1'b1
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_FIXED  = 2'd1,
        ST_BEYOND = 2'd2
    } status_t;

    typedef struct packed {
        kind_t          kind;
        logic [N-1:0]   word;
    } stage_t;

    function automatic logic is_pow2(input int p);
        return (p != 0) && ((p & (p - 1)) == 0);
    endfunction

    // position p (1-based) sits at bit N-p
    function automatic logic [N-1:0] place_data(input logic [M-1:0] d);
        logic [N-1:0] w;
        int k;
        w = '0;
        k = M;
        for (int p = 1; p <= N; p++) begin
            if (!is_pow2(p)) begin
                k = k - 1;
                w[N-p] = d[k];
            end
        end
        return w;
    endfunction

    function automatic logic [M-1:0] extract_data(input logic [N-1:0] w);
        logic [M-1:0] d;
        int k;
        d = '0;
        k = M;
        for (int p = 1; p <= N; p++) begin
            if (!is_pow2(p)) begin
                k = k - 1;
                d[k] = w[N-p];
            end
        end
        return d;
    endfunction

    function automatic logic [N-1:0] place_parity(input logic [R-1:0] s);
        logic [N-1:0] w;
        w = '0;
        for (int j = 0; j < R; j++) begin
            w[N-(1 << j)] = s[j];
        end
        return w;
    endfunction

    function automatic logic [N-1:0] group_mask(input int j);
        logic [N-1:0] g;
        g = '0;
        for (int p = 1; p <= N; p++) begin
            g[N-p] = ((p >> j) & 1) != 0;
        end
        return g;
    endfunction

endpackage

/* rtl/hsc_syndrome.sv */
// ----------------------------------------------------------------------------
// hsc_syndrome
// Parity-group reduction: one even-parity bit per syndrome bit.
// ----------------------------------------------------------------------------
module hsc_syndrome
    import hsc_pkg::*;
(
    input  logic [N-1:0] word,
    output logic [R-1:0] syn
);

    for (genvar j = 0; j < R; j++) begin : g_grp
        localparam logic [N-1:0] GMASK = group_mask(j);
        assign syn[j] = ^(word & GMASK);
    end

endmodule

/* rtl/hamming_sec_row_codec.sv */
// ----------------------------------------------------------------------------
// hamming_sec_row_codec
// Hamming single-error-correcting encoder/decoder for one data row.
// ----------------------------------------------------------------------------
// Takes one beat per cycle unless a stall on the result side has filled the
// stages. Stage one places the data bits (or takes the received codeword),
// stage two reduces the parity groups into a syndrome, stage three inserts
// parity bits or flips the named bit, extracts the data and holds the result
// in the output register. Each stage advances on its own, so a stall on the
// result side only backs up as far as the first empty stage.
// ----------------------------------------------------------------------------
module hamming_sec_row_codec
    import hsc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // data_word[31:0], code_word[69:32], zero pad
    input  logic                 s_tuser,   // kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // code_word_out, data_out, syndrome, status,
                                            // zero pad
);

    logic         v1_reg, v2_reg, v3_reg;
    logic         rdy1, rdy2, rdy3;
    stage_t       st1_reg, st1_next;
    stage_t       st2_reg;
    logic [R-1:0] syn1;
    logic [R-1:0] syn2_reg;

    logic [N-1:0]     fix_word;
    logic [N-1:0]     flip_mask;
    logic [R-1:0]     shamt;
    status_t          stat_next;
    logic [N-1:0]     code_next;
    logic [M-1:0]     data_next;
    logic [R-1:0]     syn_next;
    logic [N-1:0]     code_reg;
    logic [M-1:0]     data_reg;
    logic [R-1:0]     syn_reg;
    status_t          stat_reg;

    logic [DATA_W-1:0] in_data;
    logic [CODE_W-1:0] in_code;

    assign rdy3     = !v3_reg || m_tready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    assign in_data = s_tdata[DATA_W-1:0];
    assign in_code = s_tdata[DATA_W+CODE_W-1:DATA_W];

    // stage 1: place data bits or take received word
    always_comb begin
        st1_next.kind = kind_t'(s_tuser);
        if (s_tuser == KIND_DEC) begin
            st1_next.word = N'(in_code);
        end else begin
            st1_next.word = place_data(M'(in_data));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (rdy1) begin
            v1_reg <= s_tvalid;
        end
        if (rdy1 && s_tvalid) begin
            st1_reg <= st1_next;
        end
    end

    // stage 2: parity groups
    hsc_syndrome u_syn (
        .word (st1_reg.word),
        .syn  (syn1)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy2) begin
            v2_reg <= v1_reg;
        end
        if (rdy2 && v1_reg) begin
            st2_reg  <= st1_reg;
            syn2_reg <= syn1;
        end
    end

    // stage 3: insert parity or correct, extract data
    assign shamt     = R'(N) - syn2_reg;
    assign flip_mask = {{(N-1){1'b0}}, 1'b1} << shamt;

    always_comb begin
        fix_word  = st2_reg.word;
        stat_next = ST_OK;
        code_next = '0;
        syn_next  = '0;
        if (st2_reg.kind == KIND_DEC) begin
            syn_next = syn2_reg;
            if (syn2_reg == '0) begin
                stat_next = ST_OK;
            end else if (syn2_reg <= R'(N)) begin
                fix_word  = st2_reg.word ^ flip_mask;
                stat_next = ST_FIXED;
            end else begin
                stat_next = ST_BEYOND;
            end
        end else begin
            code_next = st2_reg.word | place_parity(syn2_reg);
        end
        data_next = extract_data(fix_word);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (rdy3) begin
            v3_reg <= v2_reg;
        end
        if (rdy3 && v2_reg) begin
            code_reg <= code_next;
            data_reg <= data_next;
            syn_reg  <= syn_next;
            stat_reg <= stat_next;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = M_TDATA_W'({STAT_W'(stat_reg), SYN_W'(syn_reg),
                                  DATA_W'(data_reg), CODE_W'(code_reg)});

endmodule

/* rtl/hsc_checker.sv */
// ----------------------------------------------------------------------------
// hsc_checker
// Port-level checks of the row Hamming SEC codec, bound to the top level.
// ----------------------------------------------------------------------------
module hsc_checker
    import hsc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    localparam int SYN_LO  = CODE_W + DATA_W;
    localparam int STAT_LO = SYN_LO + SYN_W;

    logic [CODE_W-1:0] code_f;
    logic [SYN_W-1:0]  syn_f;
    logic [STAT_W-1:0] stat_f;

    assign code_f = m_tdata[CODE_W-1:0];
    assign syn_f  = m_tdata[STAT_LO-1:SYN_LO];
    assign stat_f = m_tdata[STAT_LO+STAT_W-1:STAT_LO];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_no_result_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_ok_zero_syn: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && stat_f == ST_OK |-> syn_f == '0)
        else $error("no-error status with nonzero syndrome");

    a_fixed_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && stat_f == ST_FIXED |-> syn_f != '0 && syn_f <= SYN_W'(N)
                                            && code_f == '0)
        else $error("corrected status with syndrome outside codeword");

    a_beyond: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && stat_f != ST_OK && stat_f != ST_FIXED |->
            stat_f == ST_BEYOND && syn_f > SYN_W'(N))
        else $error("bad status or beyond-codeword status with small syndrome");

endmodule

bind hamming_sec_row_codec hsc_checker u_hsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
